// ===== rtl/core/interrupt_latency_monitor_core_assert.svh =====
// ----------------------------------------------------------------------------
// Interrupt latency monitor assertion macros
// Concurrent assertion helpers shared by the monitor RTL. They expand to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_LATENCY_MONITOR_CORE_ASSERT_SVH
`define INTERRUPT_LATENCY_MONITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk_i outside reset.
`define ILM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("interrupt latency monitor assertion failed");
// Checked on every rising edge of clk_i, reset included.
`define ILM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("interrupt latency monitor assertion failed");
`else
`define ILM_ASSERT(name, prop)
`define ILM_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== rtl/core/ilm_pkg.sv =====
// ----------------------------------------------------------------------------
// Interrupt latency monitor package
// Shared widths, event codes and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilm_pkg;

  // Width of timestamps, counters and sums.
  localparam int unsigned TsW = 64;

  // Event kinds carried in the action field.
  typedef enum logic [1:0] {
    ACT_RAISE = 2'd0,
    ACT_ENTRY = 2'd1,
    ACT_EXIT  = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_REPORT_INTERVAL = 1'b0,
    CFG_MEASURE_TX      = 1'b1
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [TsW-1:0] ReportIntervalRst = 64'd1000000000;
  localparam logic           MeasureTxRst      = 1'b1;

endpackage

// ===== rtl/core/ilm_if.sv =====
// ----------------------------------------------------------------------------
// Interrupt latency monitor channel interfaces
// Valid/ready channels for incoming interrupt events and outgoing reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Timestamped interrupt event channel.
interface ilm_event_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [ilm_pkg::TsW-1:0]  timestamp_ns;

  modport source (output valid, output action, output timestamp_ns, input ready);
  modport sink   (input valid, input action, input timestamp_ns, output ready);
endinterface

// Window report channel.
interface ilm_report_if;
  logic                     valid;
  logic                     ready;
  logic [ilm_pkg::TsW-1:0]  event_total;
  logic [ilm_pkg::TsW-1:0]  transmit_delay_total;
  logic [ilm_pkg::TsW-1:0]  service_delay_total;

  modport source (output valid, output event_total, output transmit_delay_total,
                  output service_delay_total, input ready);
  modport sink   (input valid, input event_total, input transmit_delay_total,
                  input service_delay_total, output ready);
endinterface

// ===== rtl/core/interrupt_latency_monitor_core.sv =====
// ----------------------------------------------------------------------------
// Interrupt latency monitor core
// Accumulates raise-to-entry and entry-to-exit delays and reports them per
// time window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The monitor accepts one event request per clock cycle unless stalled, and
// works through it in a single compute stage between an input register and a
// report register. The report that an entry event triggers is registered in
// the report register, which drives rpt_o. The rate is set by that one stage:
// a 64-bit subtract, add and compare per event. When a report waits at rpt_o
// without ready, the compute stage holds, the input register fills and then
// evt_i.ready drops until the report is taken. The user writes configuration via
// cfg_we_i only while no events are in flight; the block does not enforce it.
module interrupt_latency_monitor_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  ilm_event_if.sink               evt_i,
  ilm_report_if.source            rpt_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [ilm_pkg::TsW-1:0] cfg_data_i
);

  `include "interrupt_latency_monitor_core_assert.svh"

  localparam int unsigned W = ilm_pkg::TsW;

  // Configuration registers.
  logic [W-1:0] interval_q;
  logic         measure_q;

  // Input register.
  logic         in_valid_q;
  logic [1:0]   action_q;
  logic [W-1:0] ts_q;

  // Monitor state.
  logic [W-1:0] raise_time_q, raise_time_d;
  logic         raise_seen_q, raise_seen_d;
  logic [W-1:0] entry_time_q, entry_time_d;
  logic         entry_seen_q, entry_seen_d;
  logic [W-1:0] report_time_q, report_time_d;
  logic         report_armed_q, report_armed_d;
  logic [W-1:0] pair_count_q, pair_count_d;
  logic [W-1:0] transmit_sum_q, transmit_sum_d;
  logic [W-1:0] service_sum_q, service_sum_d;

  // Report register.
  logic         out_valid_q;
  logic [W-1:0] out_count_q, out_tx_q, out_svc_q;

  logic         advance;
  logic         step;
  logic         report_fire;
  logic [W-1:0] tx_acc;
  logic [W-1:0] elapsed;

  // The compute stage moves whenever the report register is free or drains.
  assign advance     = !out_valid_q || rpt_o.ready;
  assign step        = in_valid_q && advance;
  assign evt_i.ready = !in_valid_q || advance;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= ilm_pkg::ReportIntervalRst;
      measure_q  <= ilm_pkg::MeasureTxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ilm_pkg::CFG_REPORT_INTERVAL: interval_q <= cfg_data_i;
        ilm_pkg::CFG_MEASURE_TX:      measure_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register captures each accepted event request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      action_q <= evt_i.action;
      ts_q     <= evt_i.timestamp_ns;
    end
  end

  // Delay arithmetic for the event in the input register.
  assign tx_acc  = transmit_sum_q + ts_q - raise_time_q;
  assign elapsed = ts_q - report_time_q;

  // Next state and report decision for one event.
  always_comb begin
    raise_time_d   = raise_time_q;
    raise_seen_d   = raise_seen_q;
    entry_time_d   = entry_time_q;
    entry_seen_d   = entry_seen_q;
    report_time_d  = report_time_q;
    report_armed_d = report_armed_q;
    pair_count_d   = pair_count_q;
    transmit_sum_d = transmit_sum_q;
    service_sum_d  = service_sum_q;
    report_fire    = 1'b0;

    case (action_q)
      ilm_pkg::ACT_RAISE: begin
        raise_time_d = ts_q;
        raise_seen_d = 1'b1;
      end
      ilm_pkg::ACT_EXIT: begin
        if (!entry_seen_q) begin
          // An exit with no entry on record becomes the entry reference.
          entry_time_d = ts_q;
          entry_seen_d = 1'b1;
        end else begin
          pair_count_d  = pair_count_q + W'(1);
          service_sum_d = service_sum_q + ts_q - entry_time_q;
        end
      end
      ilm_pkg::ACT_ENTRY: begin
        entry_time_d = ts_q;
        entry_seen_d = 1'b1;
        if (measure_q && raise_seen_q) begin
          transmit_sum_d = tx_acc;
        end
        // Without a raise on record a measuring entry leaves the window alone.
        if (!measure_q || raise_seen_q) begin
          if (!report_armed_q) begin
            report_time_d  = ts_q;
            report_armed_d = 1'b1;
          end else if (elapsed > interval_q) begin
            report_fire    = 1'b1;
            report_time_d  = ts_q;
            pair_count_d   = '0;
            transmit_sum_d = '0;
            service_sum_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // State update, one event per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raise_time_q   <= '0;
      raise_seen_q   <= 1'b0;
      entry_time_q   <= '0;
      entry_seen_q   <= 1'b0;
      report_time_q  <= '0;
      report_armed_q <= 1'b0;
      pair_count_q   <= '0;
      transmit_sum_q <= '0;
      service_sum_q  <= '0;
    end else if (step) begin
      raise_time_q   <= raise_time_d;
      raise_seen_q   <= raise_seen_d;
      entry_time_q   <= entry_time_d;
      entry_seen_q   <= entry_seen_d;
      report_time_q  <= report_time_d;
      report_armed_q <= report_armed_d;
      pair_count_q   <= pair_count_d;
      transmit_sum_q <= transmit_sum_d;
      service_sum_q  <= service_sum_d;
    end
  end

  // Report register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && report_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && report_fire) begin
      out_count_q <= pair_count_q;
      out_tx_q    <= measure_q ? tx_acc : transmit_sum_q;
      out_svc_q   <= service_sum_q;
    end
  end

  assign rpt_o.valid                = out_valid_q;
  assign rpt_o.event_total          = out_count_q;
  assign rpt_o.transmit_delay_total = out_tx_q;
  assign rpt_o.service_delay_total  = out_svc_q;

  // No report is offered while reset is applied.
  `ILM_ASSERT_ALWAYS(a_no_report_in_reset, !rst_ni |-> !rpt_o.valid)

  // A report leaves the window counters cleared.
  `ILM_ASSERT(a_report_clears, step && report_fire |=>
    pair_count_q == '0 && transmit_sum_q == '0 && service_sum_q == '0)

  // A stalled event stays in the input register.
  `ILM_ASSERT(a_stall_holds, in_valid_q && !advance |=> in_valid_q && $stable(ts_q))

endmodule
